>>> src/bmk_pkg.sv
package bmk_pkg;

  localparam int DEFAULT_STORE_DEPTH = 512;
  localparam logic [15:0] UNIT_TICKS_RESET = 16'd300;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

  // Store code for a space; 0..25 are the letters.
  localparam logic [4:0] SPACE_CODE = 5'd26;

  // Item classes handed from the front part to the back part.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_STORE   = 2'd1;
  localparam logic [1:0] KIND_NEWLINE = 2'd2;
  localparam logic [1:0] KIND_OTHER   = 2'd3;

  // Keying phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_GAP  = 2'd1;
  localparam logic [1:0] PH_MARK = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic       led_on;
    logic       playing;
    logic       accepted;
    logic [9:0] fill_level;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] code;
  } cmd_t;

  // Number of elements in a letter.
  function automatic logic [2:0] sym_len(input logic [4:0] c);
    logic [2:0] r;
    case (c)
      5'd0: r = 3'd2;  5'd1: r = 3'd4;  5'd2: r = 3'd4;  5'd3: r = 3'd3;
      5'd4: r = 3'd1;  5'd5: r = 3'd4;  5'd6: r = 3'd3;  5'd7: r = 3'd4;
      5'd8: r = 3'd2;  5'd9: r = 3'd4;  5'd10: r = 3'd3; 5'd11: r = 3'd4;
      5'd12: r = 3'd2; 5'd13: r = 3'd2; 5'd14: r = 3'd3; 5'd15: r = 3'd4;
      5'd16: r = 3'd4; 5'd17: r = 3'd3; 5'd18: r = 3'd3; 5'd19: r = 3'd1;
      5'd20: r = 3'd3; 5'd21: r = 3'd4; 5'd22: r = 3'd3; 5'd23: r = 3'd4;
      5'd24: r = 3'd4; 5'd25: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Element pattern of a letter: bit k set means element k is a dash.
  function automatic logic [3:0] sym_bits(input logic [4:0] c);
    logic [3:0] r;
    case (c)
      5'd0: r = 4'd2;  5'd1: r = 4'd1;  5'd2: r = 4'd5;  5'd3: r = 4'd1;
      5'd4: r = 4'd0;  5'd5: r = 4'd4;  5'd6: r = 4'd3;  5'd7: r = 4'd0;
      5'd8: r = 4'd0;  5'd9: r = 4'd14; 5'd10: r = 4'd5; 5'd11: r = 4'd2;
      5'd12: r = 4'd3; 5'd13: r = 4'd1; 5'd14: r = 4'd7; 5'd15: r = 4'd6;
      5'd16: r = 4'd11; 5'd17: r = 4'd2; 5'd18: r = 4'd0; 5'd19: r = 4'd1;
      5'd20: r = 4'd4; 5'd21: r = 4'd8; 5'd22: r = 4'd6; 5'd23: r = 4'd9;
      5'd24: r = 4'd13; 5'd25: r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/bmk_ram.sv
module bmk_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/bmk_front.sv
module bmk_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  bmk_pkg::in_t    in_data,
  output logic            push,
  output bmk_pkg::cmd_t   push_cmd,
  input  logic            q_full
);

  logic          hold_v_r;
  logic          hold_v_nxt;
  bmk_pkg::cmd_t hold_r;
  bmk_pkg::cmd_t hold_nxt;
  bmk_pkg::cmd_t cls;
  logic          in_ready;
  logic [7:0]    letter_ofs;

  assign letter_ofs = in_data.char_code - bmk_pkg::CHAR_LOWER_A;

  // Sort the incoming item into one of the classes the back part knows.
  always_comb begin
    cls.kind = bmk_pkg::KIND_OTHER;
    cls.code = bmk_pkg::SPACE_CODE;
    if (!in_data.command) begin
      cls.kind = bmk_pkg::KIND_TICK;
    end else if (in_data.char_code == bmk_pkg::CHAR_NEWLINE) begin
      cls.kind = bmk_pkg::KIND_NEWLINE;
    end else if (in_data.char_code == bmk_pkg::CHAR_SPACE) begin
      cls.kind = bmk_pkg::KIND_STORE;
    end else if (in_data.char_code >= bmk_pkg::CHAR_LOWER_A &&
                 in_data.char_code <= bmk_pkg::CHAR_LOWER_Z) begin
      cls.kind = bmk_pkg::KIND_STORE;
      cls.code = letter_ofs[4:0];
    end
  end

  assign push     = hold_v_r && !q_full;
  assign in_ready = !hold_v_r || !q_full;
  assign busy     = !in_ready;
  assign push_cmd = hold_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (start && in_ready) begin
      hold_v_nxt = 1'b1;
      hold_nxt   = cls;
    end else if (push) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

>>> src/bmk_queue.sv
module bmk_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bmk_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output bmk_pkg::cmd_t head_cmd
);

  bmk_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r;
  logic          wr_ptr_nxt;
  logic          rd_ptr_r;
  logic          rd_ptr_nxt;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> src/bmk_back.sv
module bmk_back #(
  parameter int STORE_DEPTH = bmk_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  bmk_pkg::cmd_t head_cmd,
  output logic          pop,
  input  logic          cfg_wr,
  input  logic [15:0]   cfg_value,
  output logic          out_strobe,
  output bmk_pkg::out_t out_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(STORE_DEPTH);

  localparam logic SQ_RUN  = 1'b0;
  localparam logic SQ_LOAD = 1'b1;

  logic          seq_r, seq_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [19:0]   ticks_r, ticks_nxt;
  logic [FW-1:0] pos_r, pos_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [2:0]    elem_r, elem_nxt;
  logic [4:0]    code_r, code_nxt;
  logic          acc_pend_r, acc_pend_nxt;
  logic [15:0]   unit_r;
  logic          out_v_r, out_v_nxt;
  bmk_pkg::out_t out_d_r, out_d_nxt;

  logic          we;
  logic [AW-1:0] raddr;
  logic [4:0]    rdata;
  logic [4:0]    rcode;

  logic [19:0]   u1, u3, u7;
  logic [19:0]   tk;
  logic [2:0]    elem_inc;
  logic [3:0]    sym_pat;
  logic          dash;
  logic          load_req;
  logic [FW-1:0] load_pos;
  logic          acc;
  logic          emit;

  bmk_ram #(
    .WIDTH (5),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (head_cmd.code),
    .rd_addr (raddr),
    .rd_data (rdata)
  );

  // A unit length of zero counts as one. The multiples are built from shifts, an add and a subtract.
  assign u1 = (unit_r == 16'd0) ? 20'd1 : {4'd0, unit_r};
  assign u3 = (u1 << 1) + u1;
  assign u7 = (u1 << 3) - u1;

  assign tk       = ticks_r - {19'd0, (ticks_r != 20'd0)};
  assign elem_inc = elem_r + 3'd1;
  assign sym_pat  = bmk_pkg::sym_bits(code_r);
  assign dash     = sym_pat[elem_r[1:0]];
  assign rcode    = (rdata > bmk_pkg::SPACE_CODE) ? bmk_pkg::SPACE_CODE : rdata;

  always_comb begin
    seq_nxt      = seq_r;
    phase_nxt    = phase_r;
    ticks_nxt    = ticks_r;
    pos_nxt      = pos_r;
    fill_nxt     = fill_r;
    elem_nxt     = elem_r;
    code_nxt     = code_r;
    acc_pend_nxt = acc_pend_r;
    out_d_nxt    = out_d_r;
    pop          = 1'b0;
    we           = 1'b0;
    raddr        = pos_r[AW-1:0];
    load_req     = 1'b0;
    load_pos     = '0;
    acc          = 1'b0;
    emit         = 1'b0;

    unique case (seq_r)
      SQ_RUN: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head_cmd.kind)
            bmk_pkg::KIND_TICK: begin
              if (phase_r != bmk_pkg::PH_IDLE) begin
                if (tk != 20'd0) begin
                  ticks_nxt = tk;
                end else if (phase_r == bmk_pkg::PH_GAP) begin
                  if (code_r == bmk_pkg::SPACE_CODE) begin
                    load_req = 1'b1;
                    load_pos = pos_r + FW'(1);
                  end else begin
                    phase_nxt = bmk_pkg::PH_MARK;
                    ticks_nxt = dash ? u3 : u1;
                  end
                end else begin
                  elem_nxt = elem_inc;
                  if (code_r != bmk_pkg::SPACE_CODE &&
                      elem_inc < bmk_pkg::sym_len(code_r)) begin
                    phase_nxt = bmk_pkg::PH_GAP;
                    ticks_nxt = u1;
                  end else begin
                    load_req = 1'b1;
                    load_pos = pos_r + FW'(1);
                  end
                end
              end
            end
            bmk_pkg::KIND_STORE: begin
              if (phase_r == bmk_pkg::PH_IDLE) begin
                if (fill_r < DEPTH_F) begin
                  we       = 1'b1;
                  fill_nxt = fill_r + FW'(1);
                  acc      = 1'b1;
                end
                if (fill_nxt >= DEPTH_F) begin
                  load_req = 1'b1;
                end
              end
            end
            bmk_pkg::KIND_NEWLINE: begin
              if (phase_r == bmk_pkg::PH_IDLE && fill_r != '0) begin
                load_req = 1'b1;
              end
            end
            bmk_pkg::KIND_OTHER: begin
            end
          endcase

          if (load_req) begin
            if (load_pos >= fill_nxt) begin
              // Text finished: empty the store and go idle.
              phase_nxt = bmk_pkg::PH_IDLE;
              ticks_nxt = 20'd0;
              fill_nxt  = '0;
              pos_nxt   = '0;
              elem_nxt  = 3'd0;
              emit      = 1'b1;
            end else begin
              pos_nxt      = load_pos;
              raddr        = load_pos[AW-1:0];
              acc_pend_nxt = acc;
              seq_nxt      = SQ_LOAD;
            end
          end else begin
            emit = 1'b1;
          end
        end
      end
      SQ_LOAD: begin
        code_nxt  = rcode;
        elem_nxt  = 3'd0;
        phase_nxt = bmk_pkg::PH_GAP;
        ticks_nxt = (rcode == bmk_pkg::SPACE_CODE) ? u7 : u3;
        acc       = acc_pend_r;
        seq_nxt   = SQ_RUN;
        emit      = 1'b1;
      end
    endcase

    out_v_nxt = emit;
    if (emit) begin
      out_d_nxt.led_on     = (phase_nxt == bmk_pkg::PH_MARK);
      out_d_nxt.playing    = (phase_nxt != bmk_pkg::PH_IDLE);
      out_d_nxt.accepted   = acc;
      out_d_nxt.fill_level = 10'(fill_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= SQ_RUN;
      phase_r    <= bmk_pkg::PH_IDLE;
      ticks_r    <= 20'd0;
      pos_r      <= '0;
      fill_r     <= '0;
      elem_r     <= 3'd0;
      unit_r     <= bmk_pkg::UNIT_TICKS_RESET;
      out_v_r    <= 1'b0;
    end else begin
      seq_r      <= seq_nxt;
      phase_r    <= phase_nxt;
      ticks_r    <= ticks_nxt;
      pos_r      <= pos_nxt;
      fill_r     <= fill_nxt;
      elem_r     <= elem_nxt;
      out_v_r    <= out_v_nxt;
      if (cfg_wr) begin
        unit_r <= cfg_value;
      end
    end
    code_r     <= code_nxt;
    acc_pend_r <= acc_pend_nxt;
    out_d_r    <= out_d_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_data   = out_d_r;

  ap_led_implies_playing: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_d_r.led_on |-> out_d_r.playing)
    else $error("led keyed while not playing");

  ap_playing_has_text: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != bmk_pkg::PH_IDLE |-> fill_r != '0)
    else $error("playback with an empty store");

  ap_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == SQ_LOAD |=> seq_r == SQ_RUN && out_v_r)
    else $error("store read did not complete an item");

  ap_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == SQ_RUN && phase_r != bmk_pkg::PH_IDLE |-> ticks_r != 20'd0)
    else $error("keying phase with an expired timer");

  ap_no_pop_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == SQ_LOAD |-> !pop)
    else $error("queue popped during a store read");

endmodule

>>> src/buffered_morse_keyer.sv
// Buffered Morse keyer.
// Input items arrive on start/in_data and are taken at a clock edge where
// start is high and busy is low. An item is either a time tick
// (command = 0) or a received byte (command = 1). Lower-case letters and
// spaces are stored; a newline, or filling the store, starts playback, which
// then advances one step per tick. Bytes received during playback are dropped.
// Every item produces exactly one result on out_data, marked by a one-cycle
// out_strobe; the receiver must take it in that cycle, it cannot stall.
// The unit length in ticks is written over cfg_valid/cfg_ready/cfg_data,
// which is always ready; the user makes writes only while no item is in
// flight, and the block itself does not enforce this.
// A result passes the front holding register, the queue and the result
// register, and the SQ_LOAD store read (one registered RAM read) when the
// item begins a new stored character; items queued ahead of it delay it.
// The back end finishes one item per cycle except for an item that begins a
// character, which also takes the SQ_LOAD store read; a two-entry queue
// between front and back absorbs that extra state, and busy rises only when
// the front holding register and the queue are both full.
// After reset the keyer is idle with an empty store and a unit of 300 ticks.
// The character store itself is not cleared; only written entries are read.
module buffered_morse_keyer #(
  parameter int STORE_DEPTH = bmk_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bmk_pkg::in_t  in_data,
  output logic          out_strobe,
  output bmk_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  logic          push;
  bmk_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          pop;
  logic          head_valid;
  bmk_pkg::cmd_t head_cmd;

  // The unit register can take a write in any cycle.
  assign cfg_ready = 1'b1;

  // Front end: registers the transfer and classifies the byte.
  bmk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // Short queue that decouples classification from keying.
  bmk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: character store, playback timers and the result register.
  bmk_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_value  (cfg_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

>>> verif/buffered_morse_keyer_tb.sv
// Testbench for the buffered Morse keyer.
module buffered_morse_keyer_tb;

  localparam int STORE_DEPTH = bmk_pkg::DEFAULT_STORE_DEPTH;

  // Item kinds on the command field.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_CHAR = 1'b1;

  // The letter with the shortest playback.
  localparam logic [7:0] CHAR_LOWER_E = 8'd101;

  // Timing of the code, in Morse units.
  localparam int LETTER_GAP_UNITS = 3;
  localparam int WORD_GAP_UNITS   = 7;
  localparam int DASH_UNITS       = 3;

  // Spare cycles after the last result, to catch any stray strobe.
  localparam int SETTLE_CYCLES = 10;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  bmk_pkg::in_t  in_data;
  logic          out_strobe;
  bmk_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [15:0]   cfg_data;

  buffered_morse_keyer #(
    .STORE_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is bounded in time, with plenty of room for a correct run.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Keyer state as this bench expects it to be after every transfer so far.
  logic [4:0]  text_store [STORE_DEPTH];
  logic [9:0]  stored_count    = '0;
  logic [9:0]  play_index      = '0;
  logic [2:0]  element_index   = '0;
  logic [1:0]  key_phase       = bmk_pkg::PH_IDLE;
  logic [19:0] ticks_remaining = '0;
  logic [15:0] unit_ticks_cfg  = bmk_pkg::UNIT_TICKS_RESET;

  // Status words that the keyer still owes, oldest first.
  bmk_pkg::out_t awaited_status[$];

  int unsigned status_errors   = 0;
  int unsigned effective_items = 0;
  int          sender_idle_pct = 0;

  // Standard Morse for each letter code, written as dots and dashes.
  function automatic string morse_pattern(input logic [4:0] code);
    case (code)
      5'd0:  return ".-";   5'd1:  return "-..."; 5'd2:  return "-.-."; 5'd3:  return "-..";
      5'd4:  return ".";    5'd5:  return "..-."; 5'd6:  return "--.";  5'd7:  return "....";
      5'd8:  return "..";   5'd9:  return ".---"; 5'd10: return "-.-";  5'd11: return ".-..";
      5'd12: return "--";   5'd13: return "-.";   5'd14: return "---";  5'd15: return ".--.";
      5'd16: return "--.-"; 5'd17: return ".-.";  5'd18: return "...";  5'd19: return "-";
      5'd20: return "..-";  5'd21: return "...-"; 5'd22: return ".--";  5'd23: return "-..-";
      5'd24: return "-.--"; 5'd25: return "--..";
      default: return "";
    endcase
  endfunction

  // A unit setting of zero behaves as a single tick.
  function automatic int unsigned unit_length();
    return (unit_ticks_cfg == 16'd0) ? 1 : unit_ticks_cfg;
  endfunction

  // Open the character at play_index with its leading dark gap, or wrap up the
  // message and empty the store once every character has been sent.
  function automatic void load_next_char();
    if (play_index >= stored_count) begin
      key_phase       = bmk_pkg::PH_IDLE;
      ticks_remaining = '0;
      stored_count    = '0;
      play_index      = '0;
      element_index   = '0;
    end else begin
      element_index   = '0;
      key_phase       = bmk_pkg::PH_GAP;
      ticks_remaining = 20'((text_store[play_index] == bmk_pkg::SPACE_CODE ?
                             WORD_GAP_UNITS : LETTER_GAP_UNITS) * unit_length());
    end
  endfunction

  function automatic void advance_tick();
    logic [4:0] code;
    string      pattern;
    if (key_phase == bmk_pkg::PH_IDLE) return;
    if (ticks_remaining != '0) ticks_remaining--;
    if (ticks_remaining != '0) return;
    code    = text_store[play_index];
    pattern = morse_pattern(code);
    if (key_phase == bmk_pkg::PH_GAP) begin
      if (code == bmk_pkg::SPACE_CODE) begin
        play_index++;
        load_next_char();
      end else begin
        key_phase       = bmk_pkg::PH_MARK;
        ticks_remaining = 20'((pattern[int'(element_index)] == "-" ? DASH_UNITS : 1) *
                              unit_length());
      end
    end else begin
      // A mark has ended: either a short gap before the next element of the
      // same letter, or on to the next character.
      element_index++;
      if (code != bmk_pkg::SPACE_CODE && element_index < pattern.len()) begin
        key_phase       = bmk_pkg::PH_GAP;
        ticks_remaining = 20'(unit_length());
      end else begin
        play_index++;
        load_next_char();
      end
    end
  endfunction

  // Apply one transfer to the expected keyer state and return the status
  // word that the keyer must report for it.
  function automatic bmk_pkg::out_t keyer_step(input logic command,
                                               input logic [7:0] char_code);
    bmk_pkg::out_t status;
    logic          stored;
    stored = 1'b0;
    if (command == CMD_TICK) begin
      if (key_phase != bmk_pkg::PH_IDLE) effective_items++;
      advance_tick();
    end else if (key_phase == bmk_pkg::PH_IDLE) begin
      if (char_code == bmk_pkg::CHAR_NEWLINE) begin
        if (stored_count != '0) begin
          effective_items++;
          play_index = '0;
          load_next_char();
        end
      end else if ((char_code >= bmk_pkg::CHAR_LOWER_A &&
                    char_code <= bmk_pkg::CHAR_LOWER_Z) ||
                   char_code == bmk_pkg::CHAR_SPACE) begin
        if (stored_count < STORE_DEPTH) begin
          text_store[stored_count] = (char_code == bmk_pkg::CHAR_SPACE) ?
                                     bmk_pkg::SPACE_CODE :
                                     5'(char_code - bmk_pkg::CHAR_LOWER_A);
          stored_count++;
          stored = 1'b1;
          effective_items++;
        end
        // The character that fills the store also starts playback.
        if (stored_count >= STORE_DEPTH) begin
          play_index = '0;
          load_next_char();
        end
      end
    end
    status.led_on     = (key_phase == bmk_pkg::PH_MARK);
    status.playing    = (key_phase != bmk_pkg::PH_IDLE);
    status.accepted   = stored;
    status.fill_level = stored_count;
    return status;
  endfunction

  function automatic void log_error(input string msg);
    status_errors++;
    if (status_errors <= 10) $display("%s", msg);
  endfunction

  // Every strobe must match the oldest awaited status word, field by field.
  // The keyer cannot be stalled, so each strobe is a completed transfer.
  always @(posedge clk) begin : status_check
    bmk_pkg::out_t want;
    if (rst_n && out_strobe) begin
      if (awaited_status.size() == 0) begin
        log_error($sformatf("unexpected status: led=%0d playing=%0d accepted=%0d fill=%0d",
                            out_data.led_on, out_data.playing, out_data.accepted,
                            out_data.fill_level));
      end else begin
        want = awaited_status.pop_front();
        if (out_data.led_on !== want.led_on || out_data.playing !== want.playing ||
            out_data.accepted !== want.accepted || out_data.fill_level !== want.fill_level) begin
          log_error($sformatf({"status mismatch: expected led=%0d playing=%0d accepted=%0d ",
                               "fill=%0d, got led=%0d playing=%0d accepted=%0d fill=%0d"},
                              want.led_on, want.playing, want.accepted, want.fill_level,
                              out_data.led_on, out_data.playing, out_data.accepted,
                              out_data.fill_level));
        end
      end
    end
  end

  // Present one item, with random idle cycles first, and hold it until the
  // transfer happens. On return start is still high, so the caller either
  // sends the next item right away or lowers start in the same step.
  task automatic send_item(input logic command, input logic [7:0] char_code);
    while ($urandom_range(99) < sender_idle_pct) begin
      start   <= 1'b0;
      in_data <= 9'($urandom);
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= {command, char_code};
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_status.push_back(keyer_step(command, char_code));
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
  endtask

  // The unit length is only changed with nothing in flight.
  task automatic write_unit_ticks(input logic [15:0] value);
    wait_for_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid      <= 1'b0;
    unit_ticks_cfg = value;
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_item(CMD_CHAR, text[i]);
  endtask

  // Tick until the message has been sent. The char_code of a tick is noise.
  task automatic play_out(input int drop_pct);
    while (key_phase != bmk_pkg::PH_IDLE) begin
      if ($urandom_range(99) < drop_pct) begin
        send_item(CMD_CHAR, 8'($urandom_range(255)));
      end else begin
        send_item(CMD_TICK, 8'($urandom_range(255)));
      end
    end
  endtask

  // Mostly letters, some spaces, a little junk; never a newline.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    case ($urandom_range(99)) inside
      [0:79]:  c = 8'(bmk_pkg::CHAR_LOWER_A + $urandom_range(25));
      [80:91]: c = bmk_pkg::CHAR_SPACE;
      default: c = 8'($urandom_range(255));
    endcase
    return (c == bmk_pkg::CHAR_NEWLINE) ? bmk_pkg::CHAR_SPACE : c;
  endfunction

  // Idle keyer after reset: ticks, a newline on an empty store and bytes
  // outside the stored set must all leave it untouched.
  task automatic test_idle_inputs();
    send_item(CMD_TICK, 8'd0);
    send_item(CMD_CHAR, bmk_pkg::CHAR_NEWLINE);
    send_item(CMD_CHAR, 8'd0);
    send_item(CMD_CHAR, 8'd255);
    send_item(CMD_CHAR, bmk_pkg::CHAR_LOWER_A - 8'd1);
    send_item(CMD_CHAR, bmk_pkg::CHAR_LOWER_Z + 8'd1);
    send_item(CMD_CHAR, 8'd65);
    send_item(CMD_TICK, 8'd255);
  endtask

  // A short message with a word gap. Characters and a newline that arrive
  // during playback must be dropped.
  task automatic test_short_message();
    write_unit_ticks(16'd1);
    send_text("eta q");
    send_item(CMD_CHAR, bmk_pkg::CHAR_NEWLINE);
    send_item(CMD_TICK, 8'd0);
    send_item(CMD_CHAR, bmk_pkg::CHAR_LOWER_Z);
    send_item(CMD_CHAR, bmk_pkg::CHAR_NEWLINE);
    play_out(0);
  endtask

  // A unit setting of zero must time like a unit of one.
  task automatic test_zero_unit();
    write_unit_ticks(16'd0);
    send_text("k y");
    send_item(CMD_CHAR, bmk_pkg::CHAR_NEWLINE);
    play_out(0);
  endtask

  // Fill the store to the brim: the last character is stored and starts
  // playback on the same transfer, and anything after it is dropped. The
  // fill is mostly short letters to keep the playback brief.
  task automatic test_full_store();
    write_unit_ticks(16'd1);
    while (key_phase == bmk_pkg::PH_IDLE) begin
      if ($urandom_range(7) == 0) begin
        send_item(CMD_CHAR, text_char());
      end else begin
        send_item(CMD_CHAR, CHAR_LOWER_E);
      end
    end
    send_item(CMD_CHAR, bmk_pkg::CHAR_LOWER_A);
    send_item(CMD_CHAR, bmk_pkg::CHAR_NEWLINE);
    play_out(2);
  endtask

  // A long unit: the gap and mark timers count far past a single unit.
  task automatic test_long_unit();
    write_unit_ticks(16'd200);
    send_item(CMD_CHAR, CHAR_LOWER_E);
    send_item(CMD_CHAR, bmk_pkg::CHAR_NEWLINE);
    play_out(0);
    write_unit_ticks(bmk_pkg::UNIT_TICKS_RESET);
  endtask

  // Random messages: mostly well-formed runs of characters ended by a newline
  // and played to the end, the rest random bursts of any item.
  task automatic test_random_traffic(input int unsigned item_goal);
    int unsigned first_count;
    int unsigned length;
    first_count = effective_items;
    while (effective_items - first_count < item_goal) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(9))
          0:       write_unit_ticks(16'd0);
          1, 2, 3: write_unit_ticks(16'($urandom_range(2, 4)));
          default: write_unit_ticks(16'd1);
        endcase
      end
      if ($urandom_range(99) < 85) begin
        play_out(0);
        length = $urandom_range(1, 6);
        repeat (length) begin
          if ($urandom_range(9) == 0) send_item(CMD_TICK, 8'($urandom_range(255)));
          send_item(CMD_CHAR, text_char());
        end
        send_item(CMD_CHAR, bmk_pkg::CHAR_NEWLINE);
        play_out(5);
      end else begin
        length = $urandom_range(1, 12);
        repeat (length) begin
          case ($urandom_range(3))
            0:       send_item(CMD_CHAR, bmk_pkg::CHAR_NEWLINE);
            1:       send_item(CMD_CHAR, text_char());
            default: send_item(1'($urandom), 8'($urandom_range(255)));
          endcase
        end
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles about a third of the time.
    sender_idle_pct = 34;
    test_idle_inputs();
    test_short_message();
    test_zero_unit();
    test_full_store();
    test_random_traffic(250);

    // Sender idles most of the time.
    sender_idle_pct = 72;
    test_random_traffic(250);

    // Back-to-back transfers.
    sender_idle_pct = 0;
    test_random_traffic(250);
    test_long_unit();

    wait_for_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (status_errors == 0 && awaited_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
